// ===== src/sp_dma_register_block_assert.svh =====
// Assertion macros for the SP DMA register block.
// Used by sp_dma_register_block.sv; no other dependencies.
`ifndef SP_DMA_REGISTER_BLOCK_ASSERT_SVH
`define SP_DMA_REGISTER_BLOCK_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SDRB_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define SDRB_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== src/sdrb_pkg.sv =====
// Package for the SP DMA register block: operation codes, register indexes,
// address masks and memory sizes. No dependencies.
`default_nettype none

package sdrb_pkg;

    localparam int LOCAL_MEM_BYTES = 4096;
    localparam int DRAM_ADDR_BITS  = 24;

    // Beat-aligned masks for the local and DRAM address spaces; DRAM_WR_MASK keeps all 24 bits
    localparam logic [11:0] LOCAL_MASK    = 12'(LOCAL_MEM_BYTES - 1) & 12'hFF8;
    localparam logic [23:0] DRAM_WR_MASK  = 24'((64'd1 << DRAM_ADDR_BITS) - 64'd1);
    localparam logic [23:0] DRAM_MASK     = DRAM_WR_MASK & 24'hFFFFF8;
    localparam logic [11:0] DONE_LEN      = 12'hFF8;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [2:0] REG_SP_ADDR   = 3'd0;
    localparam logic [2:0] REG_DRAM_ADDR = 3'd1;
    localparam logic [2:0] REG_RD_LEN    = 3'd2;
    localparam logic [2:0] REG_WR_LEN    = 3'd3;
    localparam logic [2:0] REG_STATUS    = 3'd4;
    localparam logic [2:0] REG_FULL      = 3'd5;
    localparam logic [2:0] REG_BUSY      = 3'd6;
    localparam logic [2:0] REG_SEMAPHORE = 3'd7;

    // Status store: halt, broke, single step, intr-on-break, signals 0..7
    typedef logic [11:0] status_t;
    localparam status_t STATUS_RESET = 12'h001;

endpackage

`default_nettype wire

// ===== src/sp_dma_register_block.sv =====
// SP DMA register block top level: register file, strided DMA address
// sequencer and registered result stage. Depends on sdrb_pkg and
// sp_dma_register_block_assert.svh.
//
//  channel | handshake           | beat contents
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_stall | op, reg_index, write_data
//  out     | out_valid/out_stall | read_data, beat_*, interrupt_line,
//          |                     | access_error
//
// Every input beat yields exactly one result beat, in the cycle after it is
// taken. All register and address arithmetic sits between the state
// registers and the result register, so a new beat is taken every cycle
// while the result register drains.
// Reset (rst_n low, asynchronous) clears the state and valid registers and sets halt.
// in_stall rises only when a result is held and out_stall is high.
`default_nettype none
`include "sp_dma_register_block_assert.svh"

module sp_dma_register_block
    import sdrb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [2:0]  reg_index,
    input  wire logic [31:0] write_data,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      read_data,
    output logic             beat_valid,
    output logic             beat_to_dram,
    output logic             beat_imem,
    output logic [11:0]      beat_local_addr,
    output logic [23:0]      beat_dram_addr,
    output logic             beat_last,
    output logic             interrupt_line,
    output logic             access_error
);

    // ---------------------------------------------------------------
    // Architectural state
    // ---------------------------------------------------------------
    logic [12:0] shadow_local_reg, shadow_local_next;
    logic [23:0] shadow_dram_reg,  shadow_dram_next;
    logic [11:0] cur_local_reg,    cur_local_next;
    logic        cur_bank_reg,     cur_bank_next;
    logic [23:0] cur_dram_reg,     cur_dram_next;
    logic [31:0] length_reg,       length_next;
    logic [12:0] row_bytes_reg,    row_bytes_next;
    logic [8:0]  beat_in_row_reg,  beat_in_row_next;
    logic [7:0]  rows_left_reg,    rows_left_next;
    logic        busy_reg,         busy_next;
    logic        dir_reg,          dir_next;
    status_t     status_reg,       status_next;
    logic        sem_reg,          sem_next;
    logic        irq_reg,          irq_next;

    // Result stage
    logic        out_valid_reg;
    logic [31:0] rd_reg,    rd_next;
    logic        bv_reg,    bv_next;
    logic        bdir_reg,  bdir_next;
    logic        bimem_reg, bimem_next;
    logic [11:0] bloc_reg,  bloc_next;
    logic [23:0] bdram_reg, bdram_next;
    logic        blast_reg, blast_next;
    logic        err_reg,   err_next;

    logic        accept;

    // Datapath helpers
    logic [11:0] beat_off;
    logic [11:0] beat_local;
    logic [23:0] beat_dram;
    logic [9:0]  row_beats;
    logic        row_end;
    logic [11:0] skip;
    logic [11:0] local_row_next;
    logic [23:0] dram_row;
    logic [23:0] dram_row_skip;
    logic [31:0] status_word;
    status_t     status_wr;

    // Hold the input while a finished result waits downstream
    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    // Beat address arithmetic for the current position in the row
    assign beat_off       = {beat_in_row_reg, 3'b000};
    assign beat_local     = (cur_local_reg + beat_off) & LOCAL_MASK;
    assign beat_dram      = (cur_dram_reg + {12'b0, beat_off}) & DRAM_MASK;
    assign row_beats      = row_bytes_reg[12:3];
    assign row_end        = ({1'b0, beat_in_row_reg} + 10'd1) >= row_beats;
    assign skip           = length_reg[31:20];
    assign local_row_next = (cur_local_reg + row_bytes_reg[11:0]) & LOCAL_MASK;
    assign dram_row       = cur_dram_reg + {11'b0, row_bytes_reg};
    assign dram_row_skip  = dram_row + {12'b0, skip};

    // Status as seen on a read: full flags always clear, busy from the DMA
    assign status_word = {17'b0, status_reg[11:4], status_reg[3:2], 2'b00,
                          busy_reg, status_reg[1:0]};

    // Status write: set/clear pairs, both together leave the bit alone;
    // halt clear wins over halt set, and broke has a clear bit only
    always_comb
    begin
        status_wr = status_reg;
        if (write_data[0])
        begin
            status_wr[0] = 1'b0;
        end
        else if (write_data[1])
        begin
            status_wr[0] = 1'b1;
        end
        if (write_data[2])
        begin
            status_wr[1] = 1'b0;
        end
        for (int k = 0; k < 10; k++)
        begin
            if (write_data[5 + 2 * k] && !write_data[6 + 2 * k])
            begin
                status_wr[2 + k] = 1'b0;
            end
            if (write_data[6 + 2 * k] && !write_data[5 + 2 * k])
            begin
                status_wr[2 + k] = 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Next state and result for the beat on the input
    // ---------------------------------------------------------------
    always_comb
    begin
        shadow_local_next = shadow_local_reg;
        shadow_dram_next  = shadow_dram_reg;
        cur_local_next    = cur_local_reg;
        cur_bank_next     = cur_bank_reg;
        cur_dram_next     = cur_dram_reg;
        length_next       = length_reg;
        row_bytes_next    = row_bytes_reg;
        beat_in_row_next  = beat_in_row_reg;
        rows_left_next    = rows_left_reg;
        busy_next         = busy_reg;
        dir_next          = dir_reg;
        status_next       = status_reg;
        sem_next          = sem_reg;
        irq_next          = irq_reg;

        rd_next    = 32'b0;
        bv_next    = 1'b0;
        bdir_next  = 1'b0;
        bimem_next = 1'b0;
        bloc_next  = 12'b0;
        bdram_next = 24'b0;
        blast_next = 1'b0;
        err_next   = 1'b0;

        unique case (op)
            OP_READ:
            begin
                unique case (reg_index)
                    REG_SP_ADDR:   rd_next = {19'b0, cur_bank_reg, cur_local_reg};
                    REG_DRAM_ADDR: rd_next = {8'b0, cur_dram_reg};
                    REG_RD_LEN,
                    REG_WR_LEN:    rd_next = length_reg;
                    REG_STATUS:    rd_next = status_word;
                    REG_FULL:      rd_next = 32'b0;
                    REG_BUSY:      rd_next = {31'b0, busy_reg};
                    REG_SEMAPHORE:
                    begin
                        // Reading takes the semaphore
                        rd_next  = {31'b0, sem_reg};
                        sem_next = 1'b1;
                    end
                endcase
            end
            OP_WRITE:
            begin
                unique case (reg_index)
                    REG_SP_ADDR:   shadow_local_next = write_data[12:0];
                    REG_DRAM_ADDR: shadow_dram_next  = write_data[23:0] & DRAM_WR_MASK;
                    REG_RD_LEN,
                    REG_WR_LEN:
                    begin
                        // Drop a length write while a transfer runs
                        if (!busy_reg)
                        begin
                            length_next      = write_data;
                            cur_local_next   = shadow_local_reg[11:0] & LOCAL_MASK;
                            cur_bank_next    = shadow_local_reg[12];
                            cur_dram_next    = shadow_dram_reg & DRAM_MASK;
                            row_bytes_next   = ({1'b0, write_data[11:0]} + 13'd8)
                                               & ~13'h7;
                            rows_left_next   = write_data[19:12];
                            beat_in_row_next = 9'd0;
                            dir_next         = (reg_index == REG_WR_LEN);
                            busy_next        = 1'b1;
                        end
                    end
                    REG_STATUS:
                    begin
                        status_next = status_wr;
                        if (write_data[3] && !write_data[4])
                        begin
                            irq_next = 1'b0;
                        end
                        if (write_data[4] && !write_data[3])
                        begin
                            irq_next = 1'b1;
                        end
                    end
                    REG_FULL,
                    REG_BUSY:      err_next = 1'b1;
                    REG_SEMAPHORE:
                    begin
                        if (write_data == 32'b0)
                        begin
                            sem_next = 1'b0;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                endcase
            end
            OP_TICK:
            begin
                if (busy_reg)
                begin
                    bv_next    = 1'b1;
                    bdir_next  = dir_reg;
                    bimem_next = cur_bank_reg;
                    bloc_next  = beat_local;
                    bdram_next = beat_dram;
                    if (row_end)
                    begin
                        cur_local_next   = local_row_next;
                        beat_in_row_next = 9'd0;
                        if (rows_left_reg == 8'd0)
                        begin
                            // Last row: no skip, park the done length
                            blast_next    = 1'b1;
                            cur_dram_next = dram_row & DRAM_MASK;
                            length_next   = {skip, 8'b0, DONE_LEN};
                            busy_next     = 1'b0;
                        end
                        else
                        begin
                            cur_dram_next  = dram_row_skip & DRAM_MASK;
                            rows_left_next = rows_left_reg - 8'd1;
                        end
                    end
                    else
                    begin
                        beat_in_row_next = beat_in_row_reg + 9'd1;
                    end
                end
            end
            default:
            begin
                rd_next = 32'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // State registers: advance on every accepted beat
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_local_reg <= '0;
            shadow_dram_reg  <= '0;
            cur_local_reg    <= '0;
            cur_bank_reg     <= 1'b0;
            cur_dram_reg     <= '0;
            length_reg       <= '0;
            row_bytes_reg    <= '0;
            beat_in_row_reg  <= '0;
            rows_left_reg    <= '0;
            busy_reg         <= 1'b0;
            dir_reg          <= 1'b0;
            status_reg       <= STATUS_RESET;
            sem_reg          <= 1'b0;
            irq_reg          <= 1'b0;
        end
        else if (accept)
        begin
            shadow_local_reg <= shadow_local_next;
            shadow_dram_reg  <= shadow_dram_next;
            cur_local_reg    <= cur_local_next;
            cur_bank_reg     <= cur_bank_next;
            cur_dram_reg     <= cur_dram_next;
            length_reg       <= length_next;
            row_bytes_reg    <= row_bytes_next;
            beat_in_row_reg  <= beat_in_row_next;
            rows_left_reg    <= rows_left_next;
            busy_reg         <= busy_next;
            dir_reg          <= dir_next;
            status_reg       <= status_next;
            sem_reg          <= sem_next;
            irq_reg          <= irq_next;
        end
    end

    // Result valid: set on accept, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload: hold while stalled, load on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg    <= rd_next;
            bv_reg    <= bv_next;
            bdir_reg  <= bdir_next;
            bimem_reg <= bimem_next;
            bloc_reg  <= bloc_next;
            bdram_reg <= bdram_next;
            blast_reg <= blast_next;
            err_reg   <= err_next;
        end
    end

    logic irq_out_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            irq_out_reg <= irq_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign read_data       = rd_reg;
    assign beat_valid      = bv_reg;
    assign beat_to_dram    = bdir_reg;
    assign beat_imem       = bimem_reg;
    assign beat_local_addr = bloc_reg;
    assign beat_dram_addr  = bdram_reg;
    assign beat_last       = blast_reg;
    assign interrupt_line  = irq_out_reg;
    assign access_error    = err_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `SDRB_ASSERT_NOW(a_idle_beat_zero, clk, rst_n,
        out_valid_reg && !bv_reg,
        bloc_reg == 12'b0 && bdram_reg == 24'b0 && !blast_reg && !bdir_reg,
        "beat fields set without a beat")
    `SDRB_ASSERT_NOW(a_last_ends_dma, clk, rst_n,
        out_valid_reg && blast_reg,
        bv_reg && !busy_reg,
        "last beat left the DMA busy")
    `SDRB_ASSERT_NOW(a_error_no_data, clk, rst_n,
        out_valid_reg && err_reg,
        rd_reg == 32'b0 && !bv_reg,
        "access error with read data or beat")
    `SDRB_ASSERT_NEXT(a_tick_when_busy, clk, rst_n,
        accept && op == OP_TICK && busy_reg,
        out_valid_reg && bv_reg,
        "tick on a running transfer gave no beat")

endmodule

`default_nettype wire
